// ===== hdl/clrp_pkg.sv =====
package clrp_pkg;

  // Width of a parsed value; a value above 2^VALUE_BITS - 1 is out of range.
  localparam int VALUE_BITS = 16;
  // Width of the range fields on the result port.
  localparam int OUT_BITS   = 16;
  localparam int CHAR_BITS  = 8;

  // Token queue between the classifier and the parser.
  localparam int Q_PTR_BITS = 2;
  localparam int Q_DEPTH    = 1 << Q_PTR_BITS;
  localparam int Q_CNT_BITS = Q_PTR_BITS + 1;

  // Character classes.
  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_DIGIT = 3'd1;
  localparam logic [2:0] CLS_SPACE = 3'd2;
  localparam logic [2:0] CLS_COMMA = 3'd3;
  localparam logic [2:0] CLS_DASH  = 3'd4;
  localparam logic [2:0] CLS_OTHER = 3'd5;

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
    logic       last;
  } token_t;

endpackage

// ===== hdl/clrp_front.sv =====
module clrp_front (
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [clrp_pkg::CHAR_BITS-1:0] char_code,
  input  logic                          char_valid,
  input  logic                          end_of_text,
  input  logic                          q_full,
  output logic                          q_push,
  output clrp_pkg::token_t              q_token
);

  localparam logic [clrp_pkg::CHAR_BITS-1:0] CH_COMMA = 8'h2C;
  localparam logic [clrp_pkg::CHAR_BITS-1:0] CH_DASH  = 8'h2D;
  localparam logic [clrp_pkg::CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [clrp_pkg::CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [clrp_pkg::CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [clrp_pkg::CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [clrp_pkg::CHAR_BITS-1:0] CH_NINE  = 8'h39;

  logic       is_digit;
  logic       is_space;
  logic [2:0] cls;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_space = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));

  always_comb begin
    priority if (!char_valid) begin
      cls = clrp_pkg::CLS_NONE;
    end else if (is_digit) begin
      cls = clrp_pkg::CLS_DIGIT;
    end else if (is_space) begin
      cls = clrp_pkg::CLS_SPACE;
    end else if (char_code == CH_COMMA) begin
      cls = clrp_pkg::CLS_COMMA;
    end else if (char_code == CH_DASH) begin
      cls = clrp_pkg::CLS_DASH;
    end else begin
      cls = clrp_pkg::CLS_OTHER;
    end
  end

  assign item_stall    = q_full;
  // Drop idle items that carry neither a character nor the end mark.
  assign q_push        = item_valid && !q_full && (char_valid || end_of_text);
  assign q_token.cls   = cls;
  assign q_token.digit = 4'(char_code - CH_ZERO);
  assign q_token.last  = end_of_text;

endmodule

// ===== hdl/clrp_queue.sv =====
module clrp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  clrp_pkg::token_t push_data,
  output logic             full,
  input  logic             pop,
  output clrp_pkg::token_t pop_data,
  output logic             empty
);

  clrp_pkg::token_t                   entries [clrp_pkg::Q_DEPTH];
  logic [clrp_pkg::Q_PTR_BITS-1:0]    wr_ptr;
  logic [clrp_pkg::Q_PTR_BITS-1:0]    rd_ptr;
  logic [clrp_pkg::Q_CNT_BITS-1:0]    count;

  assign full     = (count == clrp_pkg::Q_CNT_BITS'(clrp_pkg::Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("token queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("token queue pushed while full");

endmodule

// ===== hdl/clrp_back.sv =====
module clrp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  clrp_pkg::token_t             q_data,
  output logic                         q_pop,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [clrp_pkg::OUT_BITS-1:0] range_low,
  output logic [clrp_pkg::OUT_BITS-1:0] range_high,
  output logic [1:0]                   status,
  output logic                         final_flag
);

  localparam int VB = clrp_pkg::VALUE_BITS;
  localparam int OB = clrp_pkg::OUT_BITS;

  localparam logic [2:0] MODE_LEAD   = 3'd0;
  localparam logic [2:0] MODE_NUM1   = 3'd1;
  localparam logic [2:0] MODE_TRAIL1 = 3'd2;
  localparam logic [2:0] MODE_LEAD2  = 3'd3;
  localparam logic [2:0] MODE_NUM2   = 3'd4;
  localparam logic [2:0] MODE_TRAIL2 = 3'd5;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd2;
  localparam logic [1:0] ERR_RANGE   = 2'd3;

  localparam logic [1:0] ST_RANGE     = 2'd0;
  localparam logic [1:0] ST_OK        = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_OUT_RANGE = 2'd3;

  function automatic logic [OB-1:0] to_out(input logic [VB-1:0] v);
    logic [VB+OB-1:0] wide;
    wide = {{OB{1'b0}}, v};
    return wide[OB-1:0];
  endfunction

  // Parser state
  logic [2:0]    mode;
  logic [VB-1:0] acc;
  logic          ovf;
  logic [VB-1:0] pstart;
  logic [1:0]    herr;

  logic [2:0]    mode_next;
  logic [VB-1:0] acc_next;
  logic          ovf_next;
  logic [VB-1:0] pstart_next;
  logic [1:0]    herr_next;

  // Step results
  logic          rng_v;
  logic [VB-1:0] rng_lo;
  logic [VB-1:0] rng_hi;
  logic          fin_v;
  logic [1:0]    fin_st;

  logic          final_pending;
  logic [1:0]    pending_status;

  logic [VB+3:0] acc_x10;
  logic          can_load;
  logic          take;
  logic          do_close;

  // Multiply by ten and add the digit; the upper four bits flag overflow.
  assign acc_x10 = (VB+4)'({acc, 3'b000}) + (VB+4)'({acc, 1'b0}) + (VB+4)'(q_data.digit);

  assign can_load = !result_valid || !result_stall;
  assign take     = can_load && !final_pending && !q_empty;
  assign q_pop    = take;

  always_comb begin
    mode_next   = mode;
    acc_next    = acc;
    ovf_next    = ovf;
    pstart_next = pstart;
    herr_next   = herr;
    rng_v       = 1'b0;
    rng_lo      = acc;
    rng_hi      = acc;
    fin_v       = 1'b0;
    fin_st      = ST_OK;
    do_close    = 1'b0;

    if ((q_data.cls != clrp_pkg::CLS_NONE) && (herr == ERR_NONE)) begin
      unique case (q_data.cls)
        clrp_pkg::CLS_COMMA: begin
          do_close = 1'b1;
        end
        clrp_pkg::CLS_DIGIT: begin
          if (mode == MODE_LEAD || mode == MODE_NUM1 ||
              mode == MODE_LEAD2 || mode == MODE_NUM2) begin
            if (|acc_x10[VB+3:VB]) begin
              ovf_next = 1'b1;
            end else begin
              acc_next = acc_x10[VB-1:0];
            end
            mode_next = (mode == MODE_LEAD || mode == MODE_NUM1) ? MODE_NUM1 : MODE_NUM2;
          end else begin
            herr_next = ERR_INVALID;
          end
        end
        clrp_pkg::CLS_SPACE: begin
          if (mode == MODE_NUM1) begin
            mode_next = MODE_TRAIL1;
          end else if (mode == MODE_NUM2) begin
            mode_next = MODE_TRAIL2;
          end
        end
        clrp_pkg::CLS_DASH: begin
          if (mode == MODE_NUM1 || mode == MODE_TRAIL1) begin
            if (ovf) begin
              herr_next = ERR_RANGE;
            end else begin
              pstart_next = acc;
              acc_next    = '0;
              mode_next   = MODE_LEAD2;
            end
          end else begin
            herr_next = ERR_INVALID;
          end
        end
        default: begin
          herr_next = ERR_INVALID;
        end
      endcase
    end

    // A comma closes the element; so does the end mark when no error is held.
    if (q_data.last && herr_next == ERR_NONE) begin
      do_close = 1'b1;
    end

    if (do_close) begin
      unique case (mode_next)
        MODE_NUM1, MODE_TRAIL1: begin
          if (ovf_next) begin
            herr_next = ERR_RANGE;
          end else begin
            rng_v  = 1'b1;
            rng_lo = acc_next;
            rng_hi = acc_next;
          end
        end
        MODE_LEAD2: begin
          herr_next = ERR_INVALID;
        end
        MODE_NUM2, MODE_TRAIL2: begin
          if (ovf_next) begin
            herr_next = ERR_RANGE;
          end else if (pstart_next > acc_next) begin
            herr_next = ERR_INVALID;
          end else begin
            rng_v  = 1'b1;
            rng_lo = pstart_next;
            rng_hi = acc_next;
          end
        end
        default: begin
        end
      endcase
      mode_next   = MODE_LEAD;
      acc_next    = '0;
      ovf_next    = 1'b0;
      pstart_next = '0;
    end

    if (q_data.last) begin
      fin_v = 1'b1;
      unique case (herr_next)
        ERR_INVALID: fin_st = ST_INVALID;
        ERR_RANGE:   fin_st = ST_OUT_RANGE;
        default:     fin_st = ST_OK;
      endcase
      mode_next   = MODE_LEAD;
      acc_next    = '0;
      ovf_next    = 1'b0;
      pstart_next = '0;
      herr_next   = ERR_NONE;
    end
  end

  // Control and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      final_pending <= 1'b0;
      mode          <= MODE_LEAD;
      acc           <= '0;
      ovf           <= 1'b0;
      pstart        <= '0;
      herr          <= ERR_NONE;
    end else if (can_load) begin
      if (final_pending) begin
        result_valid  <= 1'b1;
        final_pending <= 1'b0;
      end else if (take) begin
        mode          <= mode_next;
        acc           <= acc_next;
        ovf           <= ovf_next;
        pstart        <= pstart_next;
        herr          <= herr_next;
        result_valid  <= rng_v || fin_v;
        // A range and the closing status on one item: hold the status back.
        final_pending <= rng_v && fin_v;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (final_pending) begin
        range_low  <= '0;
        range_high <= '0;
        status     <= pending_status;
        final_flag <= 1'b1;
      end else if (take) begin
        pending_status <= fin_st;
        if (rng_v) begin
          range_low  <= to_out(rng_lo);
          range_high <= to_out(rng_hi);
          status     <= ST_RANGE;
          final_flag <= 1'b0;
        end else begin
          range_low  <= '0;
          range_high <= '0;
          status     <= fin_st;
          final_flag <= 1'b1;
        end
      end
    end
  end

  a_pending_has_out: assert property (@(posedge clk) disable iff (rst)
    final_pending |-> result_valid)
    else $error("closing status pending without a result in the output register");
  a_final_zero_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && final_flag) |-> (range_low == '0 && range_high == '0))
    else $error("closing status carries a nonzero range");
  a_status_matches_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (final_flag == (status != ST_RANGE)))
    else $error("status code disagrees with final_flag");
  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !final_flag) |-> (range_low <= range_high))
    else $error("range result with low above high");

endmodule

// ===== hdl/cpu_list_range_parser_unit.sv =====
// Streaming parser for value lists such as "0-1,5,7-8", one character per
// transfer. Each complete element leaves as one inclusive range; the item
// that carries end_of_text adds a closing status (ok, invalid argument or
// out of range), so that item yields up to two results, issued one after
// the other. A classifier takes one item per cycle into a four-entry token
// queue while the queue is not full; the parser drains one token per cycle
// through a single multiply-by-ten accumulate and state update while the
// output is not stalled. An end item that also closes a range holds the
// parser while its closing status is issued. An item is registered in the
// token queue and then in the output register before its result appears.
module cpu_list_range_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [clrp_pkg::CHAR_BITS-1:0] char_code,
  input  logic                          char_valid,
  input  logic                          end_of_text,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [clrp_pkg::OUT_BITS-1:0]  range_low,
  output logic [clrp_pkg::OUT_BITS-1:0]  range_high,
  output logic [1:0]                    status,
  output logic                          final_flag
);

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  clrp_pkg::token_t q_in;
  clrp_pkg::token_t q_out;

  clrp_front u_front (
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .char_code   (char_code),
    .char_valid  (char_valid),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_token     (q_in)
  );

  clrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  clrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .range_low    (range_low),
    .range_high   (range_high),
    .status       (status),
    .final_flag   (final_flag)
  );

endmodule

// ===== bench/tb_cpu_list_range_parser_unit.sv =====
`timescale 1ns / 100ps

module tb_cpu_list_range_parser_unit;

  localparam int VB = clrp_pkg::VALUE_BITS;
  localparam int OB = clrp_pkg::OUT_BITS;
  localparam int CB = clrp_pkg::CHAR_BITS;
  localparam longint unsigned VALUE_LIMIT = (64'd1 << VB) - 64'd1;
  localparam int TEXT_ITEMS = 1350;
  localparam int TAIL_CYCLES = 16;

  localparam logic [CB-1:0] CH_TAB   = 8'h09;
  localparam logic [CB-1:0] CH_CR    = 8'h0D;
  localparam logic [CB-1:0] CH_SPACE = 8'h20;
  localparam logic [CB-1:0] CH_COMMA = 8'h2C;
  localparam logic [CB-1:0] CH_DASH  = 8'h2D;
  localparam logic [CB-1:0] CH_ZERO  = 8'h30;
  localparam logic [CB-1:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_RANGE        = 2'd0;
  localparam logic [1:0] ST_OK           = 2'd1;
  localparam logic [1:0] ST_INVALID      = 2'd2;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;
  localparam logic [1:0] ERR_NONE        = 2'd0;

  typedef enum logic [2:0] {
    M_LEAD, M_START, M_START_WS, M_AFTER_DASH, M_END, M_END_WS
  } parse_mode_e;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BUSY, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [CB-1:0] code;
    logic          cv;
    logic          eot;
  } text_item_t;

  typedef struct packed {
    logic [OB-1:0] low;
    logic [OB-1:0] high;
    logic [1:0]    status;
    logic          fin;
  } range_result_t;

  logic          clk;
  logic          rst;
  logic          item_valid;
  logic          item_stall;
  logic [CB-1:0] char_code;
  logic          char_valid;
  logic          end_of_text;
  logic          result_valid;
  logic          result_stall;
  logic [OB-1:0] range_low;
  logic [OB-1:0] range_high;
  logic [1:0]    status;
  logic          final_flag;

  cpu_list_range_parser_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .char_code    (char_code),
    .char_valid   (char_valid),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .range_low    (range_low),
    .range_high   (range_high),
    .status       (status),
    .final_flag   (final_flag)
  );

  text_item_t    text_q[$];
  range_result_t ranges_due[$];
  logic [CB-1:0] list_text[$];
  int            text_items;
  int            mismatches;

  // parser shadow state
  parse_mode_e   mode;
  logic [VB-1:0] acc;
  logic          acc_ovf;
  logic [VB-1:0] start_val;
  logic [1:0]    held_err;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  task automatic clear_element();
    mode = M_LEAD;
    acc = '0;
    acc_ovf = 1'b0;
    start_val = '0;
  endtask

  task automatic queue_range(input logic [VB-1:0] lo, input logic [VB-1:0] hi,
                             input logic [1:0] st, input logic fin);
    range_result_t r;
    r.low = OB'(lo);
    r.high = OB'(hi);
    r.status = st;
    r.fin = fin;
    ranges_due.push_back(r);
  endtask

  task automatic accumulate(input logic [3:0] d);
    longint unsigned nxt;
    nxt = 64'(acc);
    nxt = nxt * 10 + 64'(d);
    if (nxt > VALUE_LIMIT) acc_ovf = 1'b1;
    else acc = nxt[VB-1:0];
  endtask

  task automatic close_element();
    case (mode)
      M_START, M_START_WS: begin
        if (acc_ovf) held_err = ST_OUT_OF_RANGE;
        else queue_range(acc, acc, ST_RANGE, 1'b0);
      end
      M_AFTER_DASH: held_err = ST_INVALID;
      M_END, M_END_WS: begin
        if (acc_ovf) held_err = ST_OUT_OF_RANGE;
        else if (start_val > acc) held_err = ST_INVALID;
        else queue_range(start_val, acc, ST_RANGE, 1'b0);
      end
      default: ;
    endcase
    clear_element();
  endtask

  task automatic take_char(input logic [CB-1:0] c);
    logic [CB-1:0] dv;
    dv = c - CH_ZERO;
    if (c == CH_COMMA) begin
      close_element();
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (mode == M_LEAD || mode == M_START) begin
        accumulate(dv[3:0]);
        mode = M_START;
      end else if (mode == M_AFTER_DASH || mode == M_END) begin
        accumulate(dv[3:0]);
        mode = M_END;
      end else begin
        held_err = ST_INVALID;
      end
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      if (mode == M_START) mode = M_START_WS;
      else if (mode == M_END) mode = M_END_WS;
    end else if (c == CH_DASH) begin
      if (mode == M_START || mode == M_START_WS) begin
        if (acc_ovf) begin
          held_err = ST_OUT_OF_RANGE;
        end else begin
          start_val = acc;
          acc = '0;
          mode = M_AFTER_DASH;
        end
      end else begin
        held_err = ST_INVALID;
      end
    end else begin
      held_err = ST_INVALID;
    end
  endtask

  task automatic predict_ranges(input text_item_t it);
    if (it.cv && held_err == ERR_NONE) take_char(it.code);
    if (it.eot) begin
      if (held_err == ERR_NONE) close_element();
      queue_range('0, '0, (held_err == ERR_NONE) ? ST_OK : held_err, 1'b1);
      clear_element();
      held_err = ERR_NONE;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic put_item(input logic [CB-1:0] c, input logic cv, input logic eot);
    text_item_t it;
    it.code = c;
    it.cv = cv;
    it.eot = eot;
    text_q.push_back(it);
    if (cv || eot) text_items++;
  endtask

  task automatic put_text(input string s, input bit eot_on_last);
    for (int i = 0; i < s.len(); i++)
      put_item(s[i], 1'b1, eot_on_last && i == s.len() - 1);
  endtask

  task automatic put_char(input logic [CB-1:0] c);
    if ($urandom_range(0, 11) == 0) put_item(CB'($urandom_range(0, 255)), 1'b0, 1'b0);
    put_item(c, 1'b1, 1'b0);
  endtask

  task automatic put_ws();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) list_text.push_back(CH_SPACE);
      else list_text.push_back(CB'($urandom_range(CH_TAB, CH_CR)));
    end
  endtask

  function automatic longint unsigned pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 64'($urandom_range(0, 20));
    else if (r < 15) return 64'($urandom_range(0, 999));
    else if (r < 18) return 64'($urandom_range(0, 65535));
    else if (r == 18) return 64'(65533 + $urandom_range(0, 3));
    else return 64'(65536 + $urandom_range(0, 2000000));
  endfunction

  task automatic put_value(input longint unsigned v);
    string s;
    int zeros;
    zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) list_text.push_back(CH_ZERO);
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) list_text.push_back(s[i]);
  endtask

  // Mostly well-formed lists; emit_list inserts or drops one character in about a quarter.
  task automatic build_list();
    int n_elem;
    longint unsigned a, b, t;
    list_text.delete();
    n_elem = $urandom_range(0, 6);
    for (int e = 0; e < n_elem; e++) begin
      if (e != 0) list_text.push_back(CH_COMMA);
      put_ws();
      if ($urandom_range(0, 9) != 0) begin
        a = pick_value();
        put_value(a);
        put_ws();
        if ($urandom_range(0, 1) == 0) begin
          b = pick_value();
          if (a > b && $urandom_range(0, 9) != 0) begin
            t = a;
            a = b;
            b = t;
            list_text.delete(list_text.size() - 1);
          end
          list_text.push_back(CH_DASH);
          put_ws();
          put_value(b);
          put_ws();
        end
      end
    end
    if ($urandom_range(0, 7) == 0) list_text.push_back(CH_COMMA);
  endtask

  task automatic emit_list();
    int n, bad_at, kind, emitted;
    logic [CB-1:0] bad_ch;
    text_item_t it;
    n = list_text.size();
    bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : -1;
    kind = $urandom_range(0, 3);
    case (kind)
      0: bad_ch = CB'($urandom_range(0, 255));
      1: bad_ch = CH_DASH;
      default: bad_ch = CH_SPACE;
    endcase
    emitted = 0;
    for (int i = 0; i <= n; i++) begin
      if (i == bad_at && kind != 3) begin
        put_char(bad_ch);
        emitted++;
      end
      if (i < n && !(i == bad_at && kind == 3)) begin
        put_char(list_text[i]);
        emitted++;
      end
    end
    kind = $urandom_range(0, 2);
    if (kind == 0 && emitted != 0) begin
      it = text_q.pop_back();
      it.eot = 1'b1;
      text_q.push_back(it);
    end else if (kind == 2) begin
      put_item(CB'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      put_item(CB'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------- driver

  text_item_t drv_item;
  logic       in_xfer;
  int         burst_left;
  int         gap_left;

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || in_xfer) begin
      if (gap_left != 0) begin
        item_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (text_q.size() != 0) begin
        drv_item = text_q.pop_front();
        item_valid <= 1'b1;
        char_code <= drv_item.code;
        char_valid <= drv_item.cv;
        end_of_text <= drv_item.eot;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  rx_mode_e rx_mode;
  int       rx_left;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   result_stall <= 1'b0;
      RX_RANDOM: result_stall <= ($urandom_range(0, 1) == 1);
      RX_BUSY:   result_stall <= ($urandom_range(0, 3) != 0);
      default:   result_stall <= (rx_left[2:0] == 3'd0);
    endcase
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    range_result_t want;
    text_item_t    seen;
    if (rst) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= item_valid && !item_stall;
      if (result_valid && !result_stall) begin
        if (ranges_due.size() == 0) begin
          $error("result with nothing pending: low %0d high %0d status %0d final %0b",
                 range_low, range_high, status, final_flag);
          mismatches++;
        end else begin
          want = ranges_due.pop_front();
          if (range_low !== want.low) begin
            $error("range_low: expected %0d, got %0d", want.low, range_low);
            mismatches++;
          end
          if (range_high !== want.high) begin
            $error("range_high: expected %0d, got %0d", want.high, range_high);
            mismatches++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (final_flag !== want.fin) begin
            $error("final_flag: expected %0b, got %0b", want.fin, final_flag);
            mismatches++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        seen.code = char_code;
        seen.cv = char_valid;
        seen.eot = end_of_text;
        predict_ranges(seen);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    char_code = '0;
    char_valid = 1'b0;
    end_of_text = 1'b0;
    result_stall = 1'b0;
    burst_left = 0;
    gap_left = 0;
    rx_left = 0;
    rx_mode = RX_OPEN;
    text_items = 0;
    mismatches = 0;
    clear_element();
    held_err = ERR_NONE;

    // leading zero, empty element, range plus closing status on the end item
    put_text(",0-01,,5", 1'b1);
    // value above the limit, idle item, end without a character
    put_text("65536", 1'b0);
    put_item(8'h00, 1'b0, 1'b0);
    put_item(8'hFF, 1'b0, 1'b1);
    // trimmed whitespace, start after end
    put_text("\t9 -3", 1'b1);
    // bad token, then characters ignored after the error
    put_text("7a,", 1'b1);
    put_item(8'hFF, 1'b1, 1'b1);
    // empty list
    put_item(8'h00, 1'b0, 1'b1);

    while (text_items < TEXT_ITEMS) begin
      build_list();
      emit_list();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (text_q.size() != 0 || item_valid || ranges_due.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (ranges_due.size() != 0) begin
      $error("%0d results never arrived", ranges_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/clrp_pkg.sv
hdl/clrp_front.sv
hdl/clrp_queue.sv
hdl/clrp_back.sv
hdl/cpu_list_range_parser_unit.sv
bench/tb_cpu_list_range_parser_unit.sv
